// ===== sv/qve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qve_pkg
// types and constants shared by the quorum vote election block
// ----------------------------------------------------------------------------
package qve_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_BLOCK = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_NO_WRITE  = 3'd0,
        ST_WRITE     = 3'd1,
        ST_NEW_SERV  = 3'd2,
        ST_TIMED_OUT = 3'd3,
        ST_ELECTED   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SELF_RID   = 3'd0,
        REG_PRIOR_TERM = 3'd1,
        REG_VOTES      = 3'd2,
        REG_ELECTED    = 3'd3,
        REG_FSID       = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLK_RD,
        S_BLK_CHK,
        S_BLK_WR,
        S_END_RD,
        S_END_CHK,
        S_END_FIN,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] server_term;
        logic        overall_expired;
        logic        term_timer_expired;
        logic [63:0] blk_term;
        logic [63:0] blk_write_nr;
        logic [63:0] blk_voter;
        logic [63:0] blk_vote_for;
        logic [63:0] blk_fsid;
        logic        blk_intact;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_term;
        logic [63:0] out_write_nr;
        logic [63:0] out_vote_for;
        logic        restart_timer;
    } out_item_t;

endpackage

// ===== sv/quorum_vote_election.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quorum_vote_election
// a begin_cycle result, if any, is valid in the cycle after acceptance; a block
// transaction walks S_BLK_RD and S_BLK_CHK per filled entry, then S_BLK_WR;
// end_cycle walks S_END_RD and S_END_CHK per filled entry, then S_END_FIN and
// S_OUT; one transaction at a time; entries read one at a time from the block table
// reset (aresetn low, synchronous) clears the election state and sets defaults in the config registers
// ----------------------------------------------------------------------------
module quorum_vote_election #(
    parameter int NUM_BLOCKS = qve_pkg::NUM_BLOCKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [qve_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qve_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  qve_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output qve_pkg::out_item_t             m_data
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int FW = $clog2(NUM_BLOCKS + 1);

    logic [63:0] self_rid_reg, prior_term_reg, fsid_reg;
    logic [7:0]  votes_needed_reg;
    logic [3:0]  elected_cycles_reg;

    qve_pkg::fsm_t state_reg, state_next;
    qve_pkg::in_item_t item_reg;
    qve_pkg::out_item_t out_reg;

    logic        is_cand_reg, finished_reg, restart_reg, drop_reg;
    logic [63:0] cur_term_reg, seen_wnr_reg, chosen_reg, leader_wnr_reg;
    logic [7:0]  quorum_reg, votes_reg;
    logic [FW-1:0] fill_reg, idx_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [63:0] mem_term [NUM_BLOCKS];
    logic [63:0] mem_wnr  [NUM_BLOCKS];
    logic [63:0] mem_voter[NUM_BLOCKS];
    logic [63:0] mem_vf   [NUM_BLOCKS];
    logic [63:0] rd_t, rd_w, rd_v, rd_vf;
    logic        rd_ok;

    logic [IW-1:0] idx;
    logic          blk_ok, idx_done;
    logic [8:0]    q_inc;

    assign idx = idx_reg[IW-1:0];
    assign idx_done = (idx_reg >= fill_reg);
    assign blk_ok = (item_reg.blk_voter != 64'd0) && (item_reg.blk_fsid == fsid_reg)
        && item_reg.blk_intact && (item_reg.blk_term != 64'd0);
    assign s_ready = (state_reg == qve_pkg::S_IDLE);
    assign m_valid = (state_reg == qve_pkg::S_OUT);
    assign m_data = out_reg;
    assign q_inc = {1'b0, quorum_reg} + 9'd1;

    always_ff @(posedge aclk) begin
        if (state_reg == qve_pkg::S_BLK_WR && !drop_reg && blk_ok
            && fill_reg < FW'(NUM_BLOCKS)) begin
            mem_term[idx]  <= item_reg.blk_term;
            mem_wnr[idx]   <= item_reg.blk_write_nr;
            mem_voter[idx] <= item_reg.blk_voter;
            mem_vf[idx]    <= item_reg.blk_vote_for;
        end
        rd_t  <= mem_term[idx];
        rd_w  <= mem_wnr[idx];
        rd_v  <= mem_voter[idx];
        rd_vf <= mem_vf[idx];
        rd_ok <= valid_reg[idx];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qve_pkg::S_IDLE: begin
                if (s_valid) begin
                    if (finished_reg) state_next = qve_pkg::S_IDLE;
                    else if (s_data.operation == qve_pkg::OP_BLOCK)
                        state_next = qve_pkg::S_BLK_RD;
                    else if (s_data.operation == qve_pkg::OP_END)
                        state_next = qve_pkg::S_END_RD;
                    else if (s_data.operation == qve_pkg::OP_BEGIN) begin
                        if (s_data.server_term > prior_term_reg || s_data.overall_expired
                            || s_data.term_timer_expired)
                            state_next = qve_pkg::S_OUT;
                    end
                end
            end
            qve_pkg::S_BLK_RD:  state_next = idx_done ? qve_pkg::S_BLK_WR : qve_pkg::S_BLK_CHK;
            qve_pkg::S_BLK_CHK: state_next = qve_pkg::S_BLK_RD;
            qve_pkg::S_BLK_WR:  state_next = qve_pkg::S_IDLE;
            qve_pkg::S_END_RD:  state_next = idx_done ? qve_pkg::S_END_FIN : qve_pkg::S_END_CHK;
            qve_pkg::S_END_CHK: state_next = qve_pkg::S_END_RD;
            qve_pkg::S_END_FIN: state_next = qve_pkg::S_OUT;
            qve_pkg::S_OUT:     if (m_ready) state_next = qve_pkg::S_IDLE;
            default:            state_next = qve_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qve_pkg::S_IDLE;
            self_rid_reg <= 64'd1;
            prior_term_reg <= '0;
            votes_needed_reg <= 8'd1;
            elected_cycles_reg <= 4'd2;
            fsid_reg <= '0;
            is_cand_reg <= 1'b0;
            finished_reg <= 1'b0;
            cur_term_reg <= '0;
            seen_wnr_reg <= '0;
            chosen_reg <= '0;
            leader_wnr_reg <= '0;
            quorum_reg <= '0;
            fill_reg <= '0;
            valid_reg <= '0;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    qve_pkg::REG_SELF_RID:   self_rid_reg <= cfg_data;
                    qve_pkg::REG_PRIOR_TERM: prior_term_reg <= cfg_data;
                    qve_pkg::REG_VOTES:      votes_needed_reg <= cfg_data[7:0];
                    qve_pkg::REG_ELECTED:    elected_cycles_reg <= cfg_data[3:0];
                    qve_pkg::REG_FSID:       fsid_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                qve_pkg::S_IDLE: begin
                    qve_pkg::out_item_t o;
                    idx_reg <= '0;
                    drop_reg <= 1'b0;
                    restart_reg <= 1'b0;
                    votes_reg <= '0;
                    if (s_valid) item_reg <= s_data;
                    if (s_valid && !finished_reg
                        && s_data.operation == qve_pkg::OP_BEGIN) begin
                        valid_reg <= '0;
                        fill_reg <= '0;
                        o = '0;
                        if (s_data.server_term > prior_term_reg) begin
                            finished_reg <= 1'b1;
                            o.status = qve_pkg::ST_NEW_SERV;
                        end else if (s_data.overall_expired) begin
                            finished_reg <= 1'b1;
                            o.status = qve_pkg::ST_TIMED_OUT;
                        end else if (s_data.term_timer_expired) begin
                            is_cand_reg <= 1'b1;
                            cur_term_reg <= cur_term_reg + 64'd1;
                            chosen_reg <= self_rid_reg;
                            quorum_reg <= '0;
                            o.status = qve_pkg::ST_NO_WRITE;
                            o.out_term = cur_term_reg + 64'd1;
                            o.out_vote_for = self_rid_reg;
                            o.restart_timer = 1'b1;
                        end
                        out_reg <= o;
                    end
                end
                qve_pkg::S_BLK_CHK: begin
                    idx_reg <= idx_reg + FW'(1);
                    if (rd_ok && !drop_reg && blk_ok) begin
                        if (item_reg.blk_term < rd_t || (item_reg.blk_voter == rd_v
                            && item_reg.blk_write_nr <= rd_w))
                            drop_reg <= 1'b1;
                        else if (rd_t < item_reg.blk_term || (rd_v == item_reg.blk_voter
                            && rd_w <= item_reg.blk_write_nr))
                            valid_reg[idx] <= 1'b0;
                    end
                end
                qve_pkg::S_BLK_WR: begin
                    if (!drop_reg && blk_ok && fill_reg < FW'(NUM_BLOCKS)) begin
                        valid_reg[idx] <= 1'b1;
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
                qve_pkg::S_END_CHK: begin
                    idx_reg <= idx_reg + FW'(1);
                    if (rd_ok) begin
                        logic        cand;
                        logic [63:0] lw;
                        logic [7:0]  vt;
                        cand = is_cand_reg;
                        lw = leader_wnr_reg;
                        vt = votes_reg;
                        if (rd_t > cur_term_reg || (is_cand_reg && rd_t == cur_term_reg
                            && rd_v == rd_vf && rd_v > self_rid_reg)) begin
                            cand = 1'b0;
                            cur_term_reg <= rd_t;
                            chosen_reg <= rd_vf;
                            lw = '0;
                            vt = '0;
                            quorum_reg <= '0;
                        end
                        if (!cand && rd_v == rd_vf && rd_w > lw) begin
                            restart_reg <= 1'b1;
                            lw = rd_w;
                        end
                        if (cand && rd_vf == self_rid_reg) vt = vt + 8'd1;
                        if (rd_w > seen_wnr_reg) seen_wnr_reg <= rd_w;
                        is_cand_reg <= cand;
                        leader_wnr_reg <= lw;
                        votes_reg <= vt;
                    end
                end
                qve_pkg::S_END_FIN: begin
                    logic [7:0] q;
                    qve_pkg::out_item_t o;
                    q = quorum_reg;
                    if (is_cand_reg && votes_reg >= votes_needed_reg && quorum_reg != 8'hff)
                        q = q_inc[7:0];
                    quorum_reg <= q;
                    o = '0;
                    o.restart_timer = restart_reg;
                    if (is_cand_reg && q > {4'd0, elected_cycles_reg}) begin
                        finished_reg <= 1'b1;
                        o.status = qve_pkg::ST_ELECTED;
                        o.out_term = cur_term_reg;
                        o.out_vote_for = chosen_reg;
                    end else if (cur_term_reg != 64'd0) begin
                        seen_wnr_reg <= seen_wnr_reg + 64'd1;
                        o.status = qve_pkg::ST_WRITE;
                        o.out_term = cur_term_reg;
                        o.out_write_nr = seen_wnr_reg + 64'd1;
                        o.out_vote_for = chosen_reg;
                    end
                    out_reg <= o;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== dv/quorum_vote_election_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quorum_vote_election_tb
// Self-checking bench for the quorum vote election block. A queue of input
// transactions, directed first and then mostly well-formed election cycles
// with random content plus noise, feeds a bursty driver. A local election
// predictor runs on every accepted input and its expected results are
// compared with the result channel, which stalls on its own pattern and
// once holds off for a long stretch. Each phase uses different register
// settings; the last phase lets the election finish.
// ----------------------------------------------------------------------------
module quorum_vote_election_tb;

    localparam int NB = qve_pkg::NUM_BLOCKS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [63:0] ONES = '1;

    typedef struct {
        bit          cand;
        bit          fin;
        bit [63:0]   term;
        bit [63:0]   seen;
        bit [63:0]   chosen;
        bit [63:0]   lead;
        int unsigned qc;
        int unsigned fill;
        bit [63:0]   tt [NB];
        bit [63:0]   tw [NB];
        bit [63:0]   tv [NB];
        bit [63:0]   tf [NB];
        bit          tvld [NB];
    } elect_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [qve_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qve_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 0;
    logic s_ready;
    qve_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    qve_pkg::out_item_t m_data;

    bit [63:0] cfg_rid = 1, cfg_prior = 0, cfg_fsid = 0;
    bit [7:0] cfg_need = 1;
    bit [3:0] cfg_ecyc = 2;

    elect_t gen_st, acc_st;
    qve_pkg::in_item_t vote_q[$];
    qve_pkg::out_item_t expect_q[$];
    int n_acc = 0, n_res = 0, n_err = 0, n_phase = 0;
    int st_cnt[8];
    int burst_left = 0, gap_left = 0;
    int hold_cnt = 0, rx_cyc = 0, idle_cyc = 0;
    bit hold_req = 0, hold_done = 0;

    quorum_vote_election DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    function automatic bit stale(bit [63:0] xt, xv, xw, yt, yv, yw);
        return (xt < yt) || (xv == yv && xw <= yw);
    endfunction

    // election predictor: returns 1 when the transaction produces a result
    function automatic bit elect_step(inout elect_t s, input qve_pkg::in_item_t x,
                                      output qve_pkg::out_item_t r);
        int unsigned votes;
        bit rs;
        bit [63:0] t, w, v, vf;
        r = '0;
        votes = 0;
        rs = 0;
        if (s.fin) return 0;
        case (qve_pkg::op_t'(x.operation))
            qve_pkg::OP_BEGIN: begin
                for (int i = 0; i < NB; i++) s.tvld[i] = 0;
                s.fill = 0;
                if (x.server_term > cfg_prior) begin
                    s.fin = 1;
                    r.status = qve_pkg::ST_NEW_SERV;
                    return 1;
                end
                if (x.overall_expired) begin
                    s.fin = 1;
                    r.status = qve_pkg::ST_TIMED_OUT;
                    return 1;
                end
                if (x.term_timer_expired) begin
                    s.cand = 1;
                    s.term++;
                    s.chosen = cfg_rid;
                    s.qc = 0;
                    r.status = qve_pkg::ST_NO_WRITE;
                    r.out_term = s.term;
                    r.out_vote_for = s.chosen;
                    r.restart_timer = 1;
                    return 1;
                end
                return 0;
            end
            qve_pkg::OP_BLOCK: begin
                t = x.blk_term;
                w = x.blk_write_nr;
                v = x.blk_voter;
                vf = x.blk_vote_for;
                if (v == 0 || x.blk_fsid != cfg_fsid || !x.blk_intact || t == 0)
                    return 0;
                for (int i = 0; i < s.fill; i++) begin
                    if (s.tvld[i]) begin
                        if (stale(t, v, w, s.tt[i], s.tv[i], s.tw[i])) return 0;
                        if (stale(s.tt[i], s.tv[i], s.tw[i], t, v, w)) s.tvld[i] = 0;
                    end
                end
                if (s.fill >= NB) return 0;
                s.tt[s.fill] = t;
                s.tw[s.fill] = w;
                s.tv[s.fill] = v;
                s.tf[s.fill] = vf;
                s.tvld[s.fill] = 1;
                s.fill++;
                return 0;
            end
            qve_pkg::OP_END: begin
                for (int i = 0; i < s.fill; i++) begin
                    if (s.tvld[i]) begin
                        t = s.tt[i];
                        w = s.tw[i];
                        v = s.tv[i];
                        vf = s.tf[i];
                        if (t > s.term || (s.cand && t == s.term && v == vf && v > cfg_rid))
                        begin
                            s.cand = 0;
                            s.term = t;
                            s.chosen = vf;
                            s.lead = 0;
                            votes = 0;
                            s.qc = 0;
                        end
                        if (!s.cand && v == vf && w > s.lead) begin
                            rs = 1;
                            s.lead = w;
                        end
                        if (s.cand && vf == cfg_rid) votes++;
                        if (w > s.seen) s.seen = w;
                    end
                end
                if (s.cand && votes >= cfg_need && s.qc < 255) s.qc++;
                r.restart_timer = rs;
                if (s.cand && s.qc > cfg_ecyc) begin
                    s.fin = 1;
                    r.status = qve_pkg::ST_ELECTED;
                    r.out_term = s.term;
                    r.out_vote_for = s.chosen;
                    return 1;
                end
                if (s.term > 0) begin
                    s.seen++;
                    r.status = qve_pkg::ST_WRITE;
                    r.out_term = s.term;
                    r.out_write_nr = s.seen;
                    r.out_vote_for = s.chosen;
                    return 1;
                end
                r.status = qve_pkg::ST_NO_WRITE;
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic bit [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic qve_pkg::in_item_t mk_begin(bit [63:0] st, bit oe, bit te);
        qve_pkg::in_item_t x;
        x = '0;
        x.operation = qve_pkg::OP_BEGIN;
        x.server_term = st;
        x.overall_expired = oe;
        x.term_timer_expired = te;
        return x;
    endfunction

    function automatic qve_pkg::in_item_t mk_blk(bit [63:0] t, w, v, vf, fs, bit ok);
        qve_pkg::in_item_t x;
        x = '0;
        x.operation = qve_pkg::OP_BLOCK;
        x.blk_term = t;
        x.blk_write_nr = w;
        x.blk_voter = v;
        x.blk_vote_for = vf;
        x.blk_fsid = fs;
        x.blk_intact = ok;
        return x;
    endfunction

    function automatic qve_pkg::in_item_t mk_end();
        qve_pkg::in_item_t x;
        x = '0;
        x.operation = qve_pkg::OP_END;
        return x;
    endfunction

    // fully random transaction
    function automatic qve_pkg::in_item_t mk_noise();
        qve_pkg::in_item_t x;
        x.operation = 2'($urandom_range(0, 3));
        x.server_term = rnd64();
        x.overall_expired = 1'($urandom_range(0, 1));
        x.term_timer_expired = 1'($urandom_range(0, 1));
        x.blk_term = rnd64();
        x.blk_write_nr = rnd64();
        x.blk_voter = rnd64();
        x.blk_vote_for = rnd64();
        x.blk_fsid = rnd64();
        x.blk_intact = 1'($urandom_range(0, 1));
        return x;
    endfunction

    // queue a transaction unless it would end the election too early
    task automatic offer(qve_pkg::in_item_t x, bit allow_fin);
        elect_t tmp;
        qve_pkg::out_item_t r;
        bit has;
        tmp = gen_st;
        has = elect_step(tmp, x, r);
        if (tmp.fin && !allow_fin) return;
        gen_st = tmp;
        vote_q.push_back(x);
    endtask

    function automatic bit [63:0] pick_rid();
        case ($urandom_range(0, 4))
            0: return cfg_rid;
            1: return cfg_rid + 1;
            2: return cfg_rid - 1;
            3: return 64'd1;
            default: return 64'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic bit [63:0] safe_term();
        bit [63:0] v;
        v = rnd64();
        if (cfg_prior == ONES) return v;
        if ($urandom_range(0, 3) == 0) return cfg_prior;
        return v % (cfg_prior + 1);
    endfunction

    // one election cycle with random content, or a noise transaction
    task automatic gen_cycle(bit allow_fin);
        qve_pkg::in_item_t x;
        bit [63:0] v, vf;
        int nb;
        if ($urandom_range(0, 6) == 0) begin
            x = mk_noise();
            offer(x, allow_fin);
            return;
        end
        offer(mk_begin(safe_term(), 0, 1'($urandom_range(0, 1))), allow_fin);
        nb = $urandom_range(0, 7);
        for (int i = 0; i < nb; i++) begin
            v = pick_rid();
            vf = $urandom_range(0, 1) ? v : pick_rid();
            x = mk_blk(gen_st.term + $urandom_range(0, 2) - 1,
                       64'($urandom_range(0, 12)), v, vf,
                       $urandom_range(0, 9) == 0 ? rnd64() : cfg_fsid,
                       $urandom_range(0, 9) != 0);
            offer(x, allow_fin);
        end
        offer(mk_end(), allow_fin);
        if ($urandom_range(0, 3) == 0) offer(mk_end(), allow_fin);
    endtask

    task automatic cfg_write(qve_pkg::reg_idx_t idx, bit [63:0] d);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            qve_pkg::REG_SELF_RID:   cfg_rid = d;
            qve_pkg::REG_PRIOR_TERM: cfg_prior = d;
            qve_pkg::REG_VOTES:      cfg_need = d[7:0];
            qve_pkg::REG_ELECTED:    cfg_ecyc = d[3:0];
            qve_pkg::REG_FSID:       cfg_fsid = d;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (vote_q.size() != 0 || s_valid || expect_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        qve_pkg::out_item_t r;
        bit has;
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) begin
                n_acc++;
                has = elect_step(acc_st, s_data, r);
                if (has) expect_q.push_back(r);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 0;
                end else if (vote_q.size() > 0) begin
                    s_data <= vote_q.pop_front();
                    s_valid <= 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        qve_pkg::out_item_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_res++;
                st_cnt[m_data.status]++;
                if (expect_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result transaction status %0d",
                                              m_data.status);
                end else begin
                    e = expect_q.pop_front();
                    if (m_data !== e) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch exp st=%0d term=%h wnr=%h vf=%h rs=%b",
                                      " | act st=%0d term=%h wnr=%h vf=%h rs=%b"},
                                     e.status, e.out_term, e.out_write_nr, e.out_vote_for,
                                     e.restart_timer, m_data.status, m_data.out_term,
                                     m_data.out_write_nr, m_data.out_vote_for,
                                     m_data.restart_timer);
                    end
                end
            end
            rx_cyc++;
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 0;
            end else begin
                case ((rx_cyc / 256) % 3)
                    0: m_ready <= 1;
                    1: m_ready <= $urandom_range(0, 1);
                    default: m_ready <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc = 0;
        else idle_cyc++;
        if (idle_cyc > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int sel;
        qve_pkg::in_item_t x;
        for (int i = 0; i < 8; i++) st_cnt[i] = 0;
        gen_st = '{default: 0, tt: '{default: 0}, tw: '{default: 0}, tv: '{default: 0},
                   tf: '{default: 0}, tvld: '{default: 0}};
        acc_st = gen_st;
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        // directed: reset settings
        x = mk_end();
        x.operation = qve_pkg::OP_NONE;
        x.server_term = ONES;
        x.overall_expired = 1;
        x.term_timer_expired = 1;
        x.blk_term = ONES;
        x.blk_voter = ONES;
        x.blk_intact = 1;
        offer(x, 0);
        offer(mk_end(), 0);
        offer(mk_begin(0, 0, 0), 0);
        offer(mk_begin(0, 0, 1), 0);
        offer(mk_blk(1, 5, 0, 1, 0, 1), 0);
        offer(mk_blk(1, 5, 2, 2, ONES, 1), 0);
        offer(mk_blk(1, 5, 2, 2, 0, 0), 0);
        offer(mk_blk(0, 5, 2, 2, 0, 1), 0);
        offer(mk_blk(1, 5, 1, 1, 0, 1), 0);
        offer(mk_blk(1, 3, 1, 1, 0, 1), 0);
        offer(mk_blk(1, 9, 3, 1, 0, 1), 0);
        offer(mk_end(), 0);
        offer(mk_end(), 0);
        offer(mk_begin(0, 0, 0), 0);
        for (int i = 0; i < NB + 1; i++)
            offer(mk_blk(ONES, ONES - 64'(i), 64'(i + 2), 1, 0, 1), 0);
        offer(mk_end(), 0);
        drain();

        for (n_phase = 1; n_phase <= 6; n_phase++) begin
            cfg_write(qve_pkg::REG_SELF_RID, n_phase == 1 ? ONES : (n_phase == 2 ? 64'd1 :
                                    64'($urandom_range(2, 5))));
            cfg_write(qve_pkg::REG_PRIOR_TERM, n_phase % 2 ? ONES : rnd64());
            cfg_write(qve_pkg::REG_VOTES, n_phase == 3 ? 64'd255 : 64'($urandom_range(1, 3)));
            cfg_write(qve_pkg::REG_ELECTED, n_phase == 2 ? 64'd0 : (n_phase == 4 ? 64'd15 :
                                   64'($urandom_range(1, 15))));
            cfg_write(qve_pkg::REG_FSID, n_phase == 1 ? ONES :
                      (n_phase == 5 ? 64'd0 : rnd64()));
            if (n_phase == 3) hold_req = 1;
            while (vote_q.size() < 160) gen_cycle(0);
            drain();
        end

        // closing phase: let the election end one way
        cfg_write(qve_pkg::REG_PRIOR_TERM, 64'd100);
        cfg_write(qve_pkg::REG_VOTES, 64'd1);
        cfg_write(qve_pkg::REG_ELECTED, 64'd0);
        while (vote_q.size() < 60) gen_cycle(0);
        sel = $urandom_range(0, 2);
        if (sel == 0) offer(mk_begin(64'd101 + $urandom_range(0, 99), 0, 0), 1);
        else if (sel == 1) offer(mk_begin(0, 1, 0), 1);
        else begin
            offer(mk_begin(0, 0, 1), 1);
            offer(mk_blk(gen_st.term, 1, cfg_rid, cfg_rid, cfg_fsid, 1), 1);
            offer(mk_end(), 1);
        end
        offer(mk_begin(0, 0, 1), 1);
        offer(mk_end(), 1);
        drain();

        $display("covered %0d input transactions, %0d results over %0d register settings",
                 n_acc, n_res, n_phase + 1);
        $display("status counts: nowrite %0d write %0d newserv %0d timeout %0d elected %0d",
                 st_cnt[0], st_cnt[1], st_cnt[2], st_cnt[3], st_cnt[4]);
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", n_err);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/qve_pkg.sv
sv/quorum_vote_election.sv
dv/quorum_vote_election_tb.sv
